// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the scheduler RTL.
// Expects signals clk and rst_n in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked outside reset.
`define PTTS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication, checked outside reset.
`define PTTS_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define PTTS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/ptts_pkg.sv =====
// Shared types and codes for the periodic task tick scheduler.
// No dependencies.
package ptts_pkg;

    localparam int PERIOD_W = 32;
    localparam int SLOT_W   = 8;
    localparam int KIND_W   = 3;
    localparam int FSLOT_W  = 6;
    localparam int STAT_W   = 2;

    localparam logic [KIND_W-1:0] KIND_TICK    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_CREATE  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_DELETE  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_SUSPEND = 3'd3;
    localparam logic [KIND_W-1:0] KIND_RESUME  = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_BUSY  = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

    // Command broadcast to every cell on an accepted transaction.
    typedef struct packed {
        logic                    apply;
        logic [KIND_W-1:0]       kind;
        logic [SLOT_W-1:0]       slot;
        logic [PERIOD_W-1:0]     period;
    } cmd_t;

endpackage

// ===== hw/rtl/periodic_task_tick_scheduler.sv =====
// Top level of the periodic task tick scheduler: command decode, walk FSM, result register.
// Depends on ptts_pkg, ptts_cell and assert_macros.svh.
//
//  channel  | handshake        | payload
//  ---------+------------------+-----------------------------------
//  command  | start / busy     | kind, slot, period
//  result   | strobe (1 cycle) | status, fired, fired_slot, last
//
// Commands (create, delete, suspend, resume, unknown) answer in the cycle after
// acceptance and leave busy low, so one may follow every cycle.
// A tick keeps busy high while a token walks the cell chain, one
// slot per cycle, then a closing result; the next tick may start right after.
// Reset clears every slot. Results cannot be held off by the receiver.
module periodic_task_tick_scheduler #(
    parameter int SLOTS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  kind,
    input  logic [7:0]  slot,
    input  logic [31:0] period,
    output logic        strobe,
    output logic [1:0]  status,
    output logic        fired,
    output logic [5:0]  fired_slot,
    output logic        last
);
    import ptts_pkg::*;

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_CLOSE
    } state_t;

    state_t              state_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic                strobe_reg;
    logic [STAT_W-1:0]   status_reg;
    logic                fired_reg;
    logic [FSLOT_W-1:0]  fslot_reg;
    logic                last_reg;

    logic                accept;
    logic                is_cmd;
    logic                in_range;
    logic [STAT_W-1:0]   cmd_status;
    cmd_t                cmd;
    logic [SLOTS:0]      tok_chain;
    logic [SLOTS-1:0]    tok_vec;
    logic [SLOTS-1:0]    fire_vec;
    logic [SLOTS-1:0]    occ_vec;
    logic                any_fire;

    assign busy     = (state_reg != S_IDLE);
    assign accept   = start && !busy;
    assign is_cmd   = (kind == KIND_CREATE) || (kind == KIND_DELETE)
                   || (kind == KIND_SUSPEND) || (kind == KIND_RESUME);
    assign in_range = (slot < SLOT_W'(SLOTS));

    assign cmd.apply  = accept && is_cmd && in_range;
    assign cmd.kind   = kind;
    assign cmd.slot   = slot;
    assign cmd.period = period;

    always_comb
    begin
        cmd_status = ST_OK;
        if (is_cmd)
        begin
            if (!in_range)
                cmd_status = ST_RANGE;
            else if ((kind == KIND_CREATE) && (|occ_vec))
                cmd_status = ST_BUSY;
        end
    end

    assign tok_chain[0] = accept && (kind == KIND_TICK);

    for (genvar g = 0; g < SLOTS; g++)
    begin : g_cell
        ptts_cell #(
            .IDX (g)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .cmd     (cmd),
            .tok_in  (tok_chain[g]),
            .tok_out (tok_chain[g+1]),
            .fire    (fire_vec[g]),
            .occ_hit (occ_vec[g])
        );
    end

    // token held by each cell
    assign tok_vec  = tok_chain[SLOTS:1];
    assign any_fire = |fire_vec;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            idx_reg    <= '0;
            strobe_reg <= 1'b0;
            status_reg <= ST_OK;
            fired_reg  <= 1'b0;
            fslot_reg  <= '0;
            last_reg   <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    strobe_reg <= accept && (kind != KIND_TICK);
                    if (accept)
                    begin
                        if (kind == KIND_TICK)
                        begin
                            state_reg <= S_WALK;
                            idx_reg   <= '0;
                        end
                        else
                        begin
                            status_reg <= cmd_status;
                            fired_reg  <= 1'b0;
                            fslot_reg  <= '0;
                            last_reg   <= 1'b1;
                        end
                    end
                end
                S_WALK:
                begin
                    strobe_reg <= any_fire;
                    status_reg <= ST_OK;
                    fired_reg  <= 1'b1;
                    fslot_reg  <= FSLOT_W'(idx_reg);
                    last_reg   <= 1'b0;
                    if (idx_reg == LAST_IDX)
                        state_reg <= S_CLOSE;
                    else
                        idx_reg <= idx_reg + IDX_W'(1);
                end
                S_CLOSE:
                begin
                    strobe_reg <= 1'b1;
                    status_reg <= ST_OK;
                    fired_reg  <= 1'b0;
                    fslot_reg  <= '0;
                    last_reg   <= 1'b1;
                    state_reg  <= S_IDLE;
                end
                default:
                begin
                    strobe_reg <= 1'b0;
                    state_reg  <= S_IDLE;
                end
            endcase
        end
    end

    assign strobe     = strobe_reg;
    assign status     = status_reg;
    assign fired      = fired_reg;
    assign fired_slot = fslot_reg;
    assign last       = last_reg;

`include "assert_macros.svh"

    // only the cell holding the token may fire
    `PTTS_ASSERT(a_fire_single, $onehot0(fire_vec), "more than one cell fired")
    `PTTS_ASSERT(a_tok_single, $onehot0(tok_chain), "more than one tick token")
    `PTTS_ASSERT_IMPL(a_tok_at_idx, state_reg == S_WALK, tok_vec[idx_reg] == 1'b1,
        "token and walk index disagree")
    `PTTS_ASSERT_IMPL(a_fire_in_walk, any_fire, state_reg == S_WALK,
        "cell fired outside a tick walk")
    `PTTS_ASSERT_NEXT(a_close_result, state_reg == S_CLOSE, strobe && last && !fired,
        "tick did not end with a closing result")

endmodule

// ===== hw/rtl/ptts_cell.sv =====
// One task slot: occupied/suspended marks, reload period, countdown.
// Depends on ptts_pkg. The tick token passes through one cell per cycle.
module ptts_cell #(
    parameter int IDX = 0
) (
    input  logic           clk,
    input  logic           rst_n,
    input  ptts_pkg::cmd_t cmd,
    input  logic           tok_in,
    output logic           tok_out,
    output logic           fire,
    output logic           occ_hit
);
    import ptts_pkg::*;

    logic                tok_reg;
    logic                occ_reg;
    logic                susp_reg;
    logic [PERIOD_W-1:0] reload_reg;
    logic [PERIOD_W-1:0] cd_reg;
    logic                sel;
    logic                active;

    assign sel     = cmd.apply && (cmd.slot == SLOT_W'(IDX));
    assign active  = tok_reg && occ_reg && !susp_reg;
    assign fire    = active && (cd_reg == '0);
    assign tok_out = tok_reg;
    assign occ_hit = occ_reg && (cmd.slot == SLOT_W'(IDX));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg    <= 1'b0;
            occ_reg    <= 1'b0;
            susp_reg   <= 1'b0;
            reload_reg <= '0;
            cd_reg     <= '0;
        end
        else
        begin
            tok_reg <= tok_in;
            if (sel)
            begin
                unique case (cmd.kind)
                    KIND_CREATE:
                    begin
                        if (!occ_reg)
                        begin
                            occ_reg    <= 1'b1;
                            susp_reg   <= 1'b0;
                            reload_reg <= cmd.period;
                            cd_reg     <= cmd.period;
                        end
                    end
                    KIND_DELETE:
                    begin
                        occ_reg    <= 1'b0;
                        susp_reg   <= 1'b0;
                        reload_reg <= '0;
                        cd_reg     <= '0;
                    end
                    KIND_SUSPEND:
                    begin
                        if (occ_reg)
                            susp_reg <= 1'b1;
                    end
                    KIND_RESUME:
                    begin
                        susp_reg <= 1'b0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            else if (active)
            begin
                if (cd_reg == '0)
                    cd_reg <= reload_reg;
                else
                    cd_reg <= cd_reg - PERIOD_W'(1);
            end
        end
    end

endmodule
